// File: design/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants of the sprite blitter
// Operation and result codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package stb_pkg;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_LOAD  = 3'd1,
    OP_DRAW  = 3'd2,
    OP_MOVE  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_SCAN  = 3'd5,
    OP_READ  = 3'd6,
    OP_SPARE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_PIXEL = 2'd3
  } kind_e;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR  = 2'd2;

  localparam logic [7:0]  RstSpriteWidth  = 8'd16;
  localparam logic [7:0]  RstSpriteHeight = 8'd16;
  localparam logic [15:0] RstBaseColor    = 16'hF800;
  localparam int unsigned MaxResults      = 29;

  // Result item as it leaves the block.
  typedef struct packed {
    logic        last;
    logic [15:0] pixel_value;
    logic [7:0]  second_id;
    logic [7:0]  first_id;
    kind_e       kind;
  } result_t;

endpackage

// File: design/stb_regs.sv
// ----------------------------------------------------------------------------
// stb_regs: configuration registers
// APB-style register file holding sprite size and base color.
// ----------------------------------------------------------------------------
module stb_regs
  import stb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  width_o,
  output logic [7:0]  height_o,
  output logic [15:0] color_o
);

  logic [7:0]  width_q;
  logic [7:0]  height_q;
  logic [15:0] color_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RstSpriteWidth;
      height_q <= RstSpriteHeight;
      color_q  <= RstBaseColor;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (paddr[3:2] == REG_WIDTH)  width_q  <= pwdata[7:0];
      if (paddr[3:2] == REG_HEIGHT) height_q <= pwdata[7:0];
      if (paddr[3:2] == REG_COLOR)  color_q  <= pwdata[15:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[3:2] == REG_WIDTH)  prdata = {24'd0, width_q};
      if (paddr[3:2] == REG_HEIGHT) prdata = {24'd0, height_q};
      if (paddr[3:2] == REG_COLOR)  prdata = {16'd0, color_q};
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;
  assign color_o  = color_q;

endmodule

// File: design/stb_fb.sv
// ----------------------------------------------------------------------------
// stb_fb: framebuffer memory
// Single-port synchronous RAM of RGB565 words with a registered read.
// ----------------------------------------------------------------------------
module stb_fb #(
  parameter int unsigned Depth = 32400,
  parameter int unsigned AddrW = 15
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [15:0]      wdata_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem_q [Depth];
  logic [15:0] rdata_q;

  // Write or read one word per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sprite_table_blitter_with_collision.sv
// ----------------------------------------------------------------------------
// sprite_table_blitter_with_collision: sprite engine with AABB collision scan
// Sprite table, rectangle fill into a framebuffer RAM and pairwise overlap.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Content
// s_axis    in         tvalid/tready     one operation (op on tuser)
// m_axis    out        tvalid/tready     ack, pair, done or pixel (kind on tuser)
// apb       in         psel/penable      sprite size, base color
//
// After reset the framebuffer is cleared, one word a cycle, with no input
// taken. A clear operation does the same before its ack. Each item is
// accepted in the idle state and leaves one emit transfer per result. Between
// them a read passes through the RAM read state, a fill visits each rectangle
// position (at most w*h) in turn, and a scan tests each sprite pair in turn.
// One item at a time. A stalled output holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module sprite_table_blitter_with_collision
  import stb_pkg::*;
#(
  parameter int unsigned SPRITE_COUNT  = 8,
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 135
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // sprite_idx[7:0], pos_x[23:8], pos_y[39:24], frame_number[47:40]
  input  logic [47:0] s_axis_tdata_i,
  // op[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // first_id[7:0], second_id[15:8], pixel_value[31:16]
  output logic [31:0] m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned Pixels = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AddrW  = $clog2(Pixels);
  localparam int unsigned IdW    = $clog2(SPRITE_COUNT);
  localparam result_t     AckRes = '{last: 1'b1, pixel_value: 16'd0, second_id: 8'd0,
                                     first_id: 8'd0, kind: KIND_ACK};

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FILL, S_SCAN, S_READ, S_EMIT
  } state_e;

  logic [7:0]  cfg_w, cfg_h;
  logic [15:0] cfg_c;

  stb_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .width_o(cfg_w), .height_o(cfg_h), .color_o(cfg_c)
  );

  // Sprite table registers.
  logic [SPRITE_COUNT-1:0] act_q;
  logic [15:0]             xs_q [SPRITE_COUNT];
  logic [15:0]             ys_q [SPRITE_COUNT];

  state_e           state_q;
  logic [AddrW-1:0] addr_q;
  logic             we;
  logic [15:0]      wdata;
  logic [15:0]      rdata;
  logic [AddrW-1:0] fb_addr;
  logic [8:0]       dx_q, dy_q;
  logic [16:0]      x0_q, y0_q;
  logic [15:0]      col_q;
  logic [IdW-1:0]   pi_q, pj_q;
  logic [4:0]       npair_q;
  result_t          res_q;
  logic             after_scan_q;

  stb_fb #(.Depth(Pixels), .AddrW(AddrW)) u_fb (
    .clk_i, .we_i(we), .addr_i(fb_addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // Input fields.
  op_e         in_op;
  logic [7:0]  in_id;
  logic [15:0] in_x, in_y;
  assign in_op = op_e'(s_axis_tuser_i);
  assign in_id = s_axis_tdata_i[7:0];
  assign in_x  = s_axis_tdata_i[23:8];
  assign in_y  = s_axis_tdata_i[39:24];

  logic           id_ok, live;
  logic [IdW-1:0] id_s;
  assign id_ok = {24'd0, in_id} < SPRITE_COUNT;
  assign id_s  = in_id[IdW-1:0];
  assign live  = id_ok && act_q[id_s];

  // Fill coordinates: current pixel, with clip tests.
  logic signed [17:0] frow, fcol;
  logic               fin, row_past, col_past;
  assign frow = $signed({y0_q[16], y0_q}) + $signed({9'd0, dy_q});
  assign fcol = $signed({x0_q[16], x0_q}) + $signed({9'd0, dx_q});
  assign row_past = frow >= $signed(18'(SCREEN_HEIGHT));
  assign col_past = fcol >= $signed(18'(SCREEN_WIDTH));
  assign fin = !frow[17] && !fcol[17] && !row_past && !col_past;

  logic [AddrW+10:0] fill_addr;
  assign fill_addr = (AddrW+11)'(frow[10:0]) * (AddrW+11)'(SCREEN_WIDTH)
                   + (AddrW+11)'(fcol[10:0]);

  // Read address from the request.
  logic               rd_in;
  logic [AddrW+16:0]  rd_addr;
  assign rd_in = !in_x[15] && !in_y[15] && {16'd0, in_x} < SCREEN_WIDTH
              && {16'd0, in_y} < SCREEN_HEIGHT;
  assign rd_addr = (AddrW+17)'(in_y) * (AddrW+17)'(SCREEN_WIDTH) + (AddrW+17)'(in_x);

  // Pair overlap test on exact signed positions.
  logic signed [17:0] ax, ay, bx, by, w18, h18;
  logic               hit;
  assign ax  = 18'($signed(xs_q[pi_q]));
  assign ay  = 18'($signed(ys_q[pi_q]));
  assign bx  = 18'($signed(xs_q[pj_q]));
  assign by  = 18'($signed(ys_q[pj_q]));
  assign w18 = {10'd0, cfg_w};
  assign h18 = {10'd0, cfg_h};
  assign hit = act_q[pi_q] && act_q[pj_q] && (ax < bx + w18) && (ax + w18 > bx)
            && (ay < by + h18) && (ay + h18 > by);

  logic last_pair;
  assign last_pair = ({28'd0, pj_q} == SPRITE_COUNT - 1)
                  && ({28'd0, pi_q} == SPRITE_COUNT - 2);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_EMIT);
  assign m_axis_tdata_o  = {res_q.pixel_value, res_q.second_id, res_q.first_id};
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.last;

  // Memory port control.
  always_comb begin
    we      = 1'b0;
    wdata   = 16'd0;
    fb_addr = addr_q;
    if (state_q == S_CLEAR) begin
      we = 1'b1;
    end else if (state_q == S_FILL) begin
      we      = fin;
      wdata   = col_q;
      fb_addr = fill_addr[AddrW-1:0];
    end else if (state_q == S_IDLE) begin
      fb_addr = rd_addr[AddrW-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      act_q        <= '0;
      for (int k = 0; k < SPRITE_COUNT; k++) begin
        xs_q[k] <= '0;
        ys_q[k] <= '0;
      end
      dx_q         <= '0;
      dy_q         <= '0;
      x0_q         <= '0;
      y0_q         <= '0;
      col_q        <= '0;
      pi_q         <= '0;
      pj_q         <= '0;
      npair_q      <= '0;
      res_q        <= '0;
      after_scan_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if ({17'd0, addr_q} == Pixels - 1) begin
            addr_q <= '0;
            res_q  <= '{last: 1'b1, pixel_value: '0, second_id: '0,
                        first_id: '0, kind: KIND_ACK};
            state_q <= after_scan_q ? S_EMIT : S_IDLE;
            after_scan_q <= 1'b0;
          end else begin
            addr_q <= addr_q + AddrW'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            unique case (in_op)
              OP_LOAD: begin
                if (id_ok) begin
                  act_q[id_s] <= 1'b1;
                  xs_q[id_s]  <= in_x;
                  ys_q[id_s]  <= in_y;
                end
                res_q   <= AckRes;
                state_q <= S_EMIT;
              end
              OP_DRAW, OP_MOVE: begin
                res_q <= AckRes;
                if (live) begin
                  logic [15:0] nx, ny;
                  nx = (in_op == OP_DRAW) ? in_x : xs_q[id_s] + in_x;
                  ny = (in_op == OP_DRAW) ? in_y : ys_q[id_s] + in_y;
                  xs_q[id_s] <= nx;
                  ys_q[id_s] <= ny;
                  x0_q  <= {nx[15], nx};
                  y0_q  <= {ny[15], ny};
                  dx_q  <= '0;
                  dy_q  <= '0;
                  col_q <= cfg_c + {8'd0, in_id};
                  if (cfg_w != 8'd0 && cfg_h != 8'd0) state_q <= S_FILL;
                  else state_q <= S_EMIT;
                end else begin
                  state_q <= S_EMIT;
                end
              end
              OP_CLEAR: begin
                addr_q       <= '0;
                after_scan_q <= 1'b1;
                state_q      <= S_CLEAR;
              end
              OP_SCAN: begin
                pi_q    <= '0;
                pj_q    <= IdW'(1);
                npair_q <= '0;
                state_q <= S_SCAN;
              end
              OP_READ: begin
                res_q <= '{last: 1'b1, pixel_value: '0, second_id: '0,
                           first_id: '0, kind: KIND_PIXEL};
                after_scan_q <= rd_in;
                state_q <= S_READ;
              end
              default: begin
                res_q   <= AckRes;
                state_q <= S_EMIT;
              end
            endcase
          end
        end
        S_READ: begin
          if (after_scan_q) res_q.pixel_value <= rdata;
          after_scan_q <= 1'b0;
          state_q      <= S_EMIT;
        end
        S_FILL: begin
          // Step through the rectangle, row-major; skip the rest of a row past the right edge, stop past the bottom.
          if (row_past || {1'b0, dy_q} == {2'd0, cfg_h} - 10'd1 && (col_past
              || {1'b0, dx_q} == {2'd0, cfg_w} - 10'd1)) begin
            state_q <= S_EMIT;
          end else if (col_past || {1'b0, dx_q} == {2'd0, cfg_w} - 10'd1) begin
            dx_q <= '0;
            dy_q <= dy_q + 9'd1;
          end else begin
            dx_q <= dx_q + 9'd1;
          end
        end
        S_SCAN: begin
          if (hit && {27'd0, npair_q} < MaxResults - 1) begin
            npair_q <= npair_q + 5'd1;
            res_q <= '{last: 1'b0, pixel_value: '0, second_id: 8'(pj_q),
                       first_id: 8'(pi_q), kind: KIND_PAIR};
            after_scan_q <= 1'b1;
            state_q <= S_EMIT;
          end else if (last_pair) begin
            res_q <= '{last: 1'b1, pixel_value: '0, second_id: '0,
                       first_id: '0, kind: KIND_DONE};
            state_q <= S_EMIT;
          end
          if (!last_pair) begin
            if ({28'd0, pj_q} == SPRITE_COUNT - 1) begin
              pi_q <= pi_q + IdW'(1);
              pj_q <= pi_q + IdW'(2);
            end else begin
              pj_q <= pj_q + IdW'(1);
            end
          end else if (hit && {27'd0, npair_q} < MaxResults - 1) begin
            pi_q <= '0;
            pj_q <= '0;
          end
        end
        S_EMIT: begin
          if (m_axis_tready_i) begin
            if (res_q.kind == KIND_PAIR) begin
              if (pj_q == '0) begin
                res_q <= '{last: 1'b1, pixel_value: '0, second_id: '0,
                           first_id: '0, kind: KIND_DONE};
                state_q <= S_EMIT;
              end else begin
                state_q <= S_SCAN;
              end
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker: port-level checks of the sprite blitter
// Watches the stream ports and binds to the top level.
// ----------------------------------------------------------------------------
module stb_checker
  import stb_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // No input is taken while a result is pending.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready with result pending");

  // A scan done item closes its run.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_DONE |-> m_axis_tlast_o)
    else $error("done without last");

  // Pair items never close a run.
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_PAIR |-> !m_axis_tlast_o)
    else $error("pair with last");

endmodule

bind sprite_table_blitter_with_collision stb_checker u_stb_checker (
  .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .m_axis_tvalid_o,
  .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o, .m_axis_tlast_o
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sprite blitter with collision scan
// Drives operations on the input stream and register writes on the APB port,
// predicts every result from a local model of the sprite table and the
// framebuffer, and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stb_pkg::*;

  localparam int unsigned NSPR = 8;
  localparam int unsigned SCR_W = 240;
  localparam int unsigned SCR_H = 135;
  localparam int unsigned NPIX = SCR_W * SCR_H;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sprite_table_blitter_with_collision dut (.*);

  // Local model of the block state.
  logic        mdl_active [NSPR];
  logic [15:0] mdl_x [NSPR];
  logic [15:0] mdl_y [NSPR];
  logic [15:0] mdl_frame [NPIX];
  logic [7:0]  mdl_w;
  logic [7:0]  mdl_h;
  logic [15:0] mdl_color;

  result_t result_q[$];
  int      errors = 0;
  bit      drain_on = 1'b0;

  initial begin
    forever #6ns clk_i = ~clk_i;
  end

  initial begin
    #2000ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void model_fill(int id);
    int x0, y0, row, col;
    x0 = $signed(mdl_x[id]);
    y0 = $signed(mdl_y[id]);
    for (int dy = 0; dy < int'(mdl_h); dy++) begin
      row = y0 + dy;
      if (row >= 0 && row < SCR_H) begin
        for (int dx = 0; dx < int'(mdl_w); dx++) begin
          col = x0 + dx;
          if (col >= 0 && col < SCR_W) mdl_frame[row * SCR_W + col] = mdl_color + id[15:0];
        end
      end
    end
  endfunction

  function automatic bit boxes_overlap(int a, int b);
    int ax, ay, bx, by, w, h;
    ax = $signed(mdl_x[a]); ay = $signed(mdl_y[a]);
    bx = $signed(mdl_x[b]); by = $signed(mdl_y[b]);
    w = mdl_w; h = mdl_h;
    return ax < bx + w && ax + w > bx && ay < by + h && ay + h > by;
  endfunction

  // Applies one operation to the model and queues the results it produces.
  function automatic void predict_op(op_e op, logic [7:0] id, logic [15:0] px,
                                     logic [15:0] py);
    result_t r;
    bit ok, live;
    int n, col, row;
    ok = id < NSPR;
    live = ok && mdl_active[id[2:0]];
    r = '0;
    r.last = 1'b1;
    r.kind = KIND_ACK;
    case (op)
      OP_LOAD: if (ok) begin
        mdl_active[id] = 1'b1; mdl_x[id] = px; mdl_y[id] = py;
      end
      OP_DRAW: if (live) begin
        mdl_x[id] = px; mdl_y[id] = py; model_fill(id);
      end
      OP_MOVE: if (live) begin
        mdl_x[id] = mdl_x[id] + px; mdl_y[id] = mdl_y[id] + py; model_fill(id);
      end
      OP_CLEAR: foreach (mdl_frame[k]) mdl_frame[k] = '0;
      OP_SCAN: begin
        n = 0;
        for (int i = 0; i < NSPR; i++) begin
          for (int j = i + 1; j < NSPR; j++) begin
            if (mdl_active[i] && mdl_active[j] && boxes_overlap(i, j) &&
                n < MaxResults - 1) begin
              result_t p;
              p = '0;
              p.kind = KIND_PAIR;
              p.first_id = i[7:0];
              p.second_id = j[7:0];
              result_q.push_back(p);
              n++;
            end
          end
        end
        r.kind = KIND_DONE;
      end
      OP_READ: begin
        col = $signed(px); row = $signed(py);
        r.kind = KIND_PIXEL;
        if (col >= 0 && col < SCR_W && row >= 0 && row < SCR_H)
          r.pixel_value = mdl_frame[row * SCR_W + col];
      end
      default: ;
    endcase
    result_q.push_back(r);
  endfunction

  // Sends one operation as a single input transfer.
  task automatic send_op(op_e op, logic [7:0] id, logic [15:0] px, logic [15:0] py,
                         logic [7:0] frame = 8'($urandom));
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata_i <= {frame, py, px, id};
    s_axis_tuser_i <= op;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_op(op, id, px, py);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  mdl_w = val[7:0];
      REG_HEIGHT: mdl_h = val[7:0];
      default:    mdl_color = val[15:0];
    endcase
    @(posedge clk_i);
  endtask

  // Stops the input, waits until every predicted result has arrived, then a
  // settling pause.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Output side: random back-pressure and result checking.
  initial begin
    result_t got, want;
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '0;
        got.kind = kind_e'(m_axis_tuser_o);
        got.first_id = m_axis_tdata_o[7:0];
        got.second_id = m_axis_tdata_o[15:8];
        got.pixel_value = m_axis_tdata_o[31:16];
        got.last = m_axis_tlast_o;
        if (result_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = result_q.pop_front();
          if (got.kind != want.kind)
            report($sformatf("kind %0d want %0d", got.kind, want.kind));
          if (got.first_id != want.first_id)
            report($sformatf("first_id %0d want %0d", got.first_id, want.first_id));
          if (got.second_id != want.second_id)
            report($sformatf("second_id %0d want %0d", got.second_id, want.second_id));
          if (got.pixel_value != want.pixel_value)
            report($sformatf("pixel %h want %h", got.pixel_value, want.pixel_value));
          if (got.last != want.last)
            report($sformatf("last %0b want %0b", got.last, want.last));
        end
      end
      if (drain_on) begin
        m_axis_tready_i <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 70) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($signed($urandom_range(0, 260)) - 20);
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    send_op(OP_NOP, 8'd0, 16'h0000, 16'h0000);
    send_op(OP_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_op(OP_DRAW, 8'd1, 16'd5, 16'd5);
    send_op(OP_LOAD, 8'd200, 16'd1, 16'd1);
    send_op(OP_MOVE, 8'd255, 16'd1, 16'd1);
    send_op(OP_LOAD, 8'd0, 16'h8000, 16'h8000, 8'h00);
    send_op(OP_LOAD, 8'd1, 16'h7FFF, 16'h7FFF);
    send_op(OP_LOAD, 8'd2, 16'd0, 16'd0);
    send_op(OP_LOAD, 8'd3, 16'd8, 16'd8);
    send_op(OP_DRAW, 8'd3, 16'hFFF8, 16'hFFF8);
    send_op(OP_DRAW, 8'd2, 16'd232, 16'd127);
    send_op(OP_MOVE, 8'd1, 16'd1, 16'd1);
    send_op(OP_MOVE, 8'd1, 16'h0010, 16'h0010);
    send_op(OP_SCAN, 8'd0, 16'd0, 16'd0);
    send_op(OP_READ, 8'd0, 16'd0, 16'd0);
    send_op(OP_READ, 8'd0, 16'd239, 16'd134);
    send_op(OP_READ, 8'd0, 16'd240, 16'd0);
    send_op(OP_READ, 8'd0, 16'hFFFF, 16'd3);
    send_op(OP_READ, 8'd0, 16'd4, 16'h8000);
    send_op(OP_CLEAR, 8'd0, 16'd0, 16'd0);
    send_op(OP_READ, 8'd0, 16'd3, 16'd3);
  endtask

  task automatic test_extremes();
    wait_idle();
    write_reg(REG_WIDTH, 32'hFFFF_FF00);
    write_reg(REG_HEIGHT, 32'd0);
    write_reg(REG_COLOR, 32'hFFFF_FFFF);
    for (int i = 0; i < NSPR; i++) send_op(OP_LOAD, i[7:0], 16'd10, 16'd10);
    send_op(OP_DRAW, 8'd7, 16'd10, 16'd10);
    send_op(OP_SCAN, 8'd0, 16'd0, 16'd0);
    send_op(OP_READ, 8'd0, 16'd10, 16'd10);
    wait_idle();
    write_reg(REG_WIDTH, 32'd255);
    write_reg(REG_HEIGHT, 32'd2);
    send_op(OP_DRAW, 8'd5, 16'hFF80, 16'd60);
    send_op(OP_SCAN, 8'd0, 16'd0, 16'd0);
    send_op(OP_READ, 8'd0, 16'd100, 16'd61);
    wait_idle();
    write_reg(REG_WIDTH, 32'd1);
    write_reg(REG_HEIGHT, 32'd255);
    send_op(OP_DRAW, 8'd6, 16'd239, 16'hFFB0);
    send_op(OP_SCAN, 8'd0, 16'd0, 16'd0);
    send_op(OP_READ, 8'd0, 16'd239, 16'd100);
  endtask

  // Random phases with different sprite sizes and colors.
  task automatic test_random();
    int r;
    op_e op;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_reg(REG_WIDTH, $urandom_range(1, 24));
      write_reg(REG_HEIGHT, $urandom_range(1, 24));
      write_reg(REG_COLOR, $urandom);
      for (int k = 0; k < 75; k++) begin
        r = $urandom_range(0, 99);
        if (r < 20) op = OP_LOAD;
        else if (r < 40) op = OP_DRAW;
        else if (r < 55) op = OP_MOVE;
        else if (r < 70) op = OP_SCAN;
        else if (r < 92) op = OP_READ;
        else if (r < 94) op = OP_CLEAR;
        else op = op_e'($urandom_range(0, 7));
        if (op == OP_MOVE && $urandom_range(0, 3) != 0)
          send_op(op, 8'($urandom_range(0, 9)),
                  16'($signed($urandom_range(0, 40)) - 20),
                  16'($signed($urandom_range(0, 40)) - 20));
        else if (op == OP_CLEAR && $urandom_range(0, 1))
          send_op(OP_NOP, 8'($urandom), 16'($urandom), 16'($urandom));
        else
          send_op(op, $urandom_range(0, 9) == 9 ? 8'($urandom) : 8'($urandom_range(0, 7)),
                  rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    mdl_w = RstSpriteWidth;
    mdl_h = RstSpriteHeight;
    mdl_color = RstBaseColor;
    foreach (mdl_active[i]) begin
      mdl_active[i] = 1'b0; mdl_x[i] = '0; mdl_y[i] = '0;
    end
    foreach (mdl_frame[k]) mdl_frame[k] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extremes();
    test_random();
    drain_on = 1'b1;
    wait_idle();
    repeat (NPIX + 1000) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
